@@ design/bcc_pkg.sv @@
// ----------------------------------------------------------------------------
// bcc_pkg
// Shared types, register indexes and reset values for the button click
// classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package bcc_pkg;

  localparam int TIME_W  = 32;
  localparam int CNT_W   = 16;
  localparam int MS_W    = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int S_TDATA_W  = 40;
  localparam int M_TDATA_W  = 56;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_BUTTON_PRESENT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PULL_UP_MODE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_MS     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_CLICK_MS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_CLICK_MS   = 3'd4;

  // reset values of the registers
  localparam logic            RST_BUTTON_PRESENT  = 1'b1;
  localparam logic            RST_PULL_UP_MODE    = 1'b1;
  localparam logic [MS_W-1:0] RST_DEBOUNCE_MS     = 16'd50;
  localparam logic [MS_W-1:0] RST_DOUBLE_CLICK_MS = 16'd300;
  localparam logic [MS_W-1:0] RST_LONG_CLICK_MS   = 16'd1000;

  // item command codes
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_RESYNC = 1'b1;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  typedef struct packed {
    logic            button_present;
    logic            pull_up_mode;
    logic [MS_W-1:0] debounce_ms;
    logic [MS_W-1:0] double_click_ms;
    logic [MS_W-1:0] long_click_ms;
  } cfg_t;

  typedef struct packed {
    logic              cmd;
    logic              pin_level;
    logic [TIME_W-1:0] now_ms;
  } item_t;

  typedef struct packed {
    logic             pressed_now;
    logic [CNT_W-1:0] long_clicks;
    logic [CNT_W-1:0] double_clicks;
    logic [CNT_W-1:0] single_clicks;
  } result_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    sat_inc = (c == CNT_MAX) ? c : c + {{(CNT_W-1){1'b0}}, 1'b1};
  endfunction

  function automatic logic is_active(input logic pull_up, input logic level);
    is_active = pull_up ? ~level : level;
  endfunction

endpackage

`default_nettype wire

@@ design/bcc_core.sv @@
// ----------------------------------------------------------------------------
// bcc_core
// Classifier state and its next-state logic; the state advances by one item
// whenever the enable is high.
// ----------------------------------------------------------------------------
`default_nettype none

module bcc_core import bcc_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    en,
  input  wire cfg_t    cfg,
  input  wire item_t   item,
  output result_t      result
);

  logic              previous_raw, previous_raw_next;
  logic              stable_level, stable_level_next;
  logic [TIME_W-1:0] change_time, change_time_next;
  logic [TIME_W-1:0] press_start_time, press_start_time_next;
  logic              first_click_pending, first_click_pending_next;
  logic [TIME_W-1:0] first_click_time, first_click_time_next;
  logic              long_reported, long_reported_next;
  logic              ignore_until_release, ignore_until_release_next;
  logic [CNT_W-1:0]  single_count, single_count_next;
  logic [CNT_W-1:0]  double_count, double_count_next;
  logic [CNT_W-1:0]  long_count, long_count_next;

  logic [TIME_W-1:0] since_change;
  logic [TIME_W-1:0] since_press;
  logic [TIME_W-1:0] since_first;
  logic [TIME_W-1:0] debounce_ext;
  logic [TIME_W-1:0] double_ext;
  logic [TIME_W-1:0] long_ext;
  logic              pin_act;

  always_comb begin
    previous_raw_next         = previous_raw;
    stable_level_next         = stable_level;
    change_time_next          = change_time;
    press_start_time_next     = press_start_time;
    first_click_pending_next  = first_click_pending;
    first_click_time_next     = first_click_time;
    long_reported_next        = long_reported;
    ignore_until_release_next = ignore_until_release;
    single_count_next         = single_count;
    double_count_next         = double_count;
    long_count_next           = long_count;

    debounce_ext = {{(TIME_W-MS_W){1'b0}}, cfg.debounce_ms};
    double_ext   = {{(TIME_W-MS_W){1'b0}}, cfg.double_click_ms};
    long_ext     = {{(TIME_W-MS_W){1'b0}}, cfg.long_click_ms};
    pin_act      = is_active(cfg.pull_up_mode, item.pin_level);

    since_change = '0;
    since_press  = '0;
    since_first  = '0;

    if (item.cmd == CMD_RESYNC) begin
      single_count_next = '0;
      double_count_next = '0;
      long_count_next   = '0;
      ignore_until_release_next = 1'b0;
      if (cfg.button_present) begin
        ignore_until_release_next = pin_act;
        long_reported_next        = pin_act;
        previous_raw_next         = item.pin_level;
        stable_level_next         = item.pin_level;
        press_start_time_next     = item.now_ms;
        first_click_pending_next  = 1'b0;
        first_click_time_next     = '0;
      end
    end else if (cfg.button_present) begin
      if (item.pin_level != previous_raw) begin
        change_time_next = item.now_ms;
      end
      since_change = item.now_ms - change_time_next;
      since_press  = item.now_ms - press_start_time;
      since_first  = item.now_ms - first_click_time;

      // debounced edge
      if (since_change > debounce_ext && item.pin_level != stable_level) begin
        stable_level_next = item.pin_level;
        if (pin_act) begin
          press_start_time_next = item.now_ms;
          long_reported_next    = 1'b0;
        end else if (ignore_until_release) begin
          ignore_until_release_next = 1'b0;
        end else if (since_press >= long_ext) begin
          if (!long_reported) begin
            long_count_next = sat_inc(long_count);
          end
          first_click_pending_next = 1'b0;
        end else if (first_click_pending && since_first <= double_ext) begin
          double_count_next        = sat_inc(double_count);
          first_click_pending_next = 1'b0;
        end else begin
          first_click_pending_next = 1'b1;
          first_click_time_next    = item.now_ms;
        end
      end

      // hold check on the updated press start
      since_press = item.now_ms - press_start_time_next;
      if (is_active(cfg.pull_up_mode, stable_level_next) && !long_reported_next &&
          !ignore_until_release_next && since_press >= long_ext) begin
        long_count_next    = sat_inc(long_count_next);
        long_reported_next = 1'b1;
      end

      // expired double-click window
      since_first = item.now_ms - first_click_time_next;
      if (first_click_pending_next && !ignore_until_release_next &&
          since_first > double_ext) begin
        single_count_next        = sat_inc(single_count_next);
        first_click_pending_next = 1'b0;
      end

      previous_raw_next = item.pin_level;
    end

    result.single_clicks = single_count_next;
    result.double_clicks = double_count_next;
    result.long_clicks   = long_count_next;
    result.pressed_now   = cfg.button_present & pin_act;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_raw         <= 1'b1;
      stable_level         <= 1'b1;
      change_time          <= '0;
      press_start_time     <= '0;
      first_click_pending  <= 1'b0;
      first_click_time     <= '0;
      long_reported        <= 1'b0;
      ignore_until_release <= 1'b0;
      single_count         <= '0;
      double_count         <= '0;
      long_count           <= '0;
    end else if (en) begin
      previous_raw         <= previous_raw_next;
      stable_level         <= stable_level_next;
      change_time          <= change_time_next;
      press_start_time     <= press_start_time_next;
      first_click_pending  <= first_click_pending_next;
      first_click_time     <= first_click_time_next;
      long_reported        <= long_reported_next;
      ignore_until_release <= ignore_until_release_next;
      single_count         <= single_count_next;
      double_count         <= double_count_next;
      long_count           <= long_count_next;
    end
  end

endmodule

`default_nettype wire

@@ design/button_click_classifier.sv @@
// path: an accepted input item passes the input register, then the result register
// throughput: one item per cycle unless the master side stalls, set by the single
//   input register feeding the classifier logic and the result register behind it
// reset (rst, synchronous, active high): empties both registers, restores the
//   configuration defaults and clears the classifier state
// ----------------------------------------------------------------------------
// button_click_classifier
// Debounces timestamped push-button samples and counts single, double and
// long clicks, reporting the saturating counts for every item.
// ----------------------------------------------------------------------------
`default_nettype none

module button_click_classifier import bcc_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // configuration write port
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  // input items
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [S_TDATA_W-1:0]  s_axis_tdata,  // pin_level, now_ms[31:0], 7 zero bits
  input  wire logic                  s_axis_tuser,  // cmd
  // result items
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [M_TDATA_W-1:0]       m_axis_tdata   // single_clicks, double_clicks,
                                                    // long_clicks, pressed_now, 7 zero bits
);

  cfg_t    cfg;
  item_t   in_item;
  logic    in_valid;
  result_t result;
  result_t out_item;
  logic    out_free;
  logic    advance;

  // configuration registers; the user writes them only while the block is idle, not enforced
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.button_present  <= RST_BUTTON_PRESENT;
      cfg.pull_up_mode    <= RST_PULL_UP_MODE;
      cfg.debounce_ms     <= RST_DEBOUNCE_MS;
      cfg.double_click_ms <= RST_DOUBLE_CLICK_MS;
      cfg.long_click_ms   <= RST_LONG_CLICK_MS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BUTTON_PRESENT:  cfg.button_present  <= cfg_data[0];
        REG_PULL_UP_MODE:    cfg.pull_up_mode    <= cfg_data[0];
        REG_DEBOUNCE_MS:     cfg.debounce_ms     <= cfg_data[MS_W-1:0];
        REG_DOUBLE_CLICK_MS: cfg.double_click_ms <= cfg_data[MS_W-1:0];
        REG_LONG_CLICK_MS:   cfg.long_click_ms   <= cfg_data[MS_W-1:0];
        default: ;  // writes past the register list are dropped
      endcase
    end
  end

  // handshake: the result register frees up when empty or being taken,
  // the input register moves forward into it whenever it is free
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign advance       = in_valid && out_free;
  assign s_axis_tready = !in_valid || out_free;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item.cmd       <= s_axis_tuser;
      in_item.pin_level <= s_axis_tdata[0];
      in_item.now_ms    <= s_axis_tdata[TIME_W:1];
    end
  end

  // classifier state steps once per item leaving the input register
  bcc_core u_core (
    .clk    (clk),
    .rst    (rst),
    .en     (advance),
    .cfg    (cfg),
    .item   (in_item),
    .result (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_free) begin
      m_axis_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= result;
    end
  end

  assign m_axis_tdata = {{(M_TDATA_W - $bits(result_t)){1'b0}}, out_item};

endmodule

`default_nettype wire

@@ design/bcc_checker.sv @@
// ----------------------------------------------------------------------------
// bcc_checker
// Port-level checks on the button click classifier, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bcc_checker import bcc_pkg::*; (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 s_axis_tvalid,
  input wire logic                 s_axis_tready,
  input wire logic                 m_axis_tvalid,
  input wire logic                 m_axis_tready,
  input wire logic [M_TDATA_W-1:0] m_axis_tdata
);

  // a held result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result item withdrawn while stalled");

  // a held result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result item changed while stalled");

  // input side only stalls behind a full, stalled result register
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output back-pressure");

  // an item accepted while the result register is free passes the input and result registers
  a_latency: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && (!m_axis_tvalid || m_axis_tready)
      |=> ##1 m_axis_tvalid)
    else $error("result item missing after an accepted item");

endmodule

bind button_click_classifier bcc_checker u_bcc_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

@@ bench/bcc_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bcc_checker
// Watches the configuration port and both item streams of the button click
// classifier, keeps its own model of the debouncer and click counters, and
// compares every result item with the counts worked out for it.
// ----------------------------------------------------------------------------

module tb_bcc_checker import bcc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [S_TDATA_W-1:0]  s_axis_tdata,  // pin_level, now_ms[31:0], 7 zero bits
  input  logic                  s_axis_tuser,  // cmd
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic [M_TDATA_W-1:0]  m_axis_tdata,  // single_clicks, double_clicks,
                                               // long_clicks, pressed_now, 7 zero bits
  output int                    fail_count,
  output int                    pending
);

  localparam int RES_W = $bits(result_t);

  // configuration copy
  logic            present;
  logic            pull_up;
  logic [MS_W-1:0] deb_ms;
  logic [MS_W-1:0] dbl_ms;
  logic [MS_W-1:0] long_ms;

  // classifier state
  logic              prev_raw;
  logic              stable;
  logic [TIME_W-1:0] change_t;
  logic [TIME_W-1:0] press_t;
  logic              first_pend;
  logic [TIME_W-1:0] first_t;
  logic              long_done;
  logic              ignore_rel;
  logic [CNT_W-1:0]  n_single;
  logic [CNT_W-1:0]  n_double;
  logic [CNT_W-1:0]  n_long;

  result_t due_counts[$];
  int      n_fail = 0;

  function automatic logic pressed_level(input logic level);
    pressed_level = pull_up ? ~level : level;
  endfunction

  function automatic logic [TIME_W-1:0] elapsed(input logic [TIME_W-1:0] t,
                                                input logic [TIME_W-1:0] since);
    elapsed = t - since;
  endfunction

  function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c);
    bump = (&c) ? c : c + 1'b1;
  endfunction

  task automatic resync_classifier(input logic pin, input logic [TIME_W-1:0] t);
    logic act;
    begin
      n_single = '0;
      n_double = '0;
      n_long   = '0;
      if (!present) begin
        ignore_rel = 1'b0;
      end else begin
        act        = pressed_level(pin);
        ignore_rel = act;
        long_done  = act;
        prev_raw   = pin;
        stable     = pin;
        press_t    = t;
        first_pend = 1'b0;
        first_t    = '0;
      end
    end
  endtask

  task automatic classify_sample(input logic pin, input logic [TIME_W-1:0] t);
    begin
      if (present) begin
        if (pin != prev_raw) change_t = t;
        if (elapsed(t, change_t) > TIME_W'(deb_ms) && pin != stable) begin
          stable = pin;
          if (pressed_level(stable)) begin
            press_t   = t;
            long_done = 1'b0;
          end else if (ignore_rel) begin
            ignore_rel = 1'b0;
          end else if (elapsed(t, press_t) >= TIME_W'(long_ms)) begin
            // long release only counts if the hold check missed it
            if (!long_done) n_long = bump(n_long);
            first_pend = 1'b0;
          end else if (first_pend && elapsed(t, first_t) <= TIME_W'(dbl_ms)) begin
            n_double   = bump(n_double);
            first_pend = 1'b0;
          end else begin
            first_pend = 1'b1;
            first_t    = t;
          end
        end
        if (pressed_level(stable) && !long_done && !ignore_rel &&
            elapsed(t, press_t) >= TIME_W'(long_ms)) begin
          n_long    = bump(n_long);
          long_done = 1'b1;
        end
        if (first_pend && !ignore_rel && elapsed(t, first_t) > TIME_W'(dbl_ms)) begin
          n_single   = bump(n_single);
          first_pend = 1'b0;
        end
        prev_raw = pin;
      end
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    begin
      if (want !== got) begin
        n_fail++;
        $error("%s: expected %0d, got %0d", name, want, got);
      end
    end
  endtask

  always @(posedge clk) begin : watch
    item_t   it;
    result_t want;
    result_t got;
    if (rst) begin
      present    = RST_BUTTON_PRESENT;
      pull_up    = RST_PULL_UP_MODE;
      deb_ms     = RST_DEBOUNCE_MS;
      dbl_ms     = RST_DOUBLE_CLICK_MS;
      long_ms    = RST_LONG_CLICK_MS;
      prev_raw   = 1'b1;
      stable     = 1'b1;
      change_t   = '0;
      press_t    = '0;
      first_pend = 1'b0;
      first_t    = '0;
      long_done  = 1'b0;
      ignore_rel = 1'b0;
      n_single   = '0;
      n_double   = '0;
      n_long     = '0;
      due_counts.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_BUTTON_PRESENT:  present = cfg_data[0];
          REG_PULL_UP_MODE:    pull_up = cfg_data[0];
          REG_DEBOUNCE_MS:     deb_ms  = cfg_data[MS_W-1:0];
          REG_DOUBLE_CLICK_MS: dbl_ms  = cfg_data[MS_W-1:0];
          REG_LONG_CLICK_MS:   long_ms = cfg_data[MS_W-1:0];
          default: ;
        endcase
      end
      // results first, so an item taken at this edge cannot answer for itself
      if (m_axis_tvalid && m_axis_tready) begin
        got = result_t'(m_axis_tdata[RES_W-1:0]);
        if (due_counts.size() == 0) begin
          n_fail++;
          $error("result item arrived with nothing expected");
        end else begin
          want = due_counts.pop_front();
          check_field("single_clicks", 32'(want.single_clicks), 32'(got.single_clicks));
          check_field("double_clicks", 32'(want.double_clicks), 32'(got.double_clicks));
          check_field("long_clicks", 32'(want.long_clicks), 32'(got.long_clicks));
          check_field("pressed_now", 32'(want.pressed_now), 32'(got.pressed_now));
          check_field("padding", 32'd0, 32'(m_axis_tdata[M_TDATA_W-1:RES_W]));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        it.cmd       = s_axis_tuser;
        it.pin_level = s_axis_tdata[0];
        it.now_ms    = s_axis_tdata[TIME_W:1];
        if (it.cmd == CMD_RESYNC) resync_classifier(it.pin_level, it.now_ms);
        else classify_sample(it.pin_level, it.now_ms);
        want.single_clicks = n_single;
        want.double_clicks = n_double;
        want.long_clicks   = n_long;
        want.pressed_now   = present & pressed_level(it.pin_level);
        due_counts.push_back(want);
      end
    end
    pending    <= due_counts.size();
    fail_count <= n_fail;
  end

endmodule

@@ bench/tb_button_click_classifier.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_button_click_classifier
// Drives timestamped button samples and resync commands into the click
// classifier under a series of debounce, window and polarity settings,
// with random gaps on both streams and a long output stall in two of the
// phases. A checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------

module tb_button_click_classifier;
  import bcc_pkg::*;

  // receiver hold-off used to back the block up into its input
  localparam int STALL_CYCLES = 60;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [S_TDATA_W-1:0]  s_axis_tdata = '0;  // pin_level, now_ms[31:0], 7 zero bits
  logic                  s_axis_tuser = 1'b0; // cmd
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_axis_tdata;       // single_clicks, double_clicks,
                                             // long_clicks, pressed_now, 7 zero bits
  int                    fail_count;
  int                    pending;

  // stimulus side view of the settings, used only to shape the timing
  logic        c_pull;
  int          deb;
  int          dbl;
  int          lng;
  logic [31:0] now_t = '0;
  int          n_sent = 0;
  logic        calm = 1'b0;   // no idling on either side while set
  int          hold_req = 0;  // bumped to ask the receiver for one long stall
  int          hold_done = 0;

  // opening walk-through at the reset settings (active low, debounce 50,
  // window 300, long 1000): single, double, long held then released, resync
  // while held, ignored release, and the top of the time range
  item_t script [25] = '{
    {CMD_SAMPLE, 1'b1, 32'd0},
    {CMD_SAMPLE, 1'b0, 32'd10},
    {CMD_SAMPLE, 1'b0, 32'd61},     // press taken
    {CMD_SAMPLE, 1'b1, 32'd100},
    {CMD_SAMPLE, 1'b1, 32'd151},    // short release arms a first click
    {CMD_SAMPLE, 1'b1, 32'd452},    // window gone, single click
    {CMD_SAMPLE, 1'b0, 32'd500},
    {CMD_SAMPLE, 1'b0, 32'd551},
    {CMD_SAMPLE, 1'b1, 32'd600},
    {CMD_SAMPLE, 1'b1, 32'd651},
    {CMD_SAMPLE, 1'b0, 32'd700},
    {CMD_SAMPLE, 1'b0, 32'd751},
    {CMD_SAMPLE, 1'b1, 32'd800},
    {CMD_SAMPLE, 1'b1, 32'd851},    // second release inside the window, double
    {CMD_SAMPLE, 1'b0, 32'd900},
    {CMD_SAMPLE, 1'b0, 32'd951},
    {CMD_SAMPLE, 1'b0, 32'd1951},   // held for exactly the long time
    {CMD_SAMPLE, 1'b1, 32'd2000},
    {CMD_SAMPLE, 1'b1, 32'd2051},   // long release, must not count again
    {CMD_SAMPLE, 1'b0, 32'd2100},
    {CMD_RESYNC, 1'b0, 32'd2110},   // resync with the button held
    {CMD_SAMPLE, 1'b0, 32'd3200},   // ignored press, no long click
    {CMD_SAMPLE, 1'b1, 32'd3300},
    {CMD_SAMPLE, 1'b1, 32'd3351},   // ignored press released, nothing counted
    {CMD_RESYNC, 1'b1, 32'hFFFF_FFFF}
  };

  button_click_classifier u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  tb_bcc_checker u_check (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fail_count    (fail_count),
    .pending       (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #1_000_000;
    $display("Mismatches found");
    $finish;
  end

  // receiver: ready drops on about 13 draws in 100, none while calm; on request
  // it holds ready low through a long stall so the block backs up
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req != hold_done) begin
        m_axis_tready <= 1'b0;
        repeat (STALL_CYCLES) @(posedge clk);
        hold_done++;
      end else begin
        m_axis_tready <= calm || ($urandom_range(99) >= 13);
      end
    end
  end

  // offer one item, with random idle cycles ahead of it, and wait until taken
  task automatic send_item(input logic cmd, input logic pin, input logic [31:0] t);
    begin
      while (!calm && $urandom_range(99) < 13) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tuser  <= cmd;
      s_axis_tdata  <= {{(S_TDATA_W-TIME_W-1){1'b0}}, t, pin};
      @(posedge clk);
      while (!s_axis_tready) @(posedge clk);
      n_sent++;
    end
  endtask

  // wait for every result, then let the pipeline settle before touching config
  task automatic drain();
    begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
      while (pending != 0) @(posedge clk);
      repeat (4) @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    begin
      cfg_we    <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= val;
      @(posedge clk);
    end
  endtask

  task automatic set_config(input logic present, input logic pull, input int d,
                            input int w, input int l);
    begin
      drain();
      write_reg(REG_BUTTON_PRESENT, CFG_DATA_W'(present));
      write_reg(REG_PULL_UP_MODE, CFG_DATA_W'(pull));
      write_reg(REG_DEBOUNCE_MS, CFG_DATA_W'(d));
      write_reg(REG_DOUBLE_CLICK_MS, CFG_DATA_W'(w));
      write_reg(REG_LONG_CLICK_MS, CFG_DATA_W'(l));
      cfg_we <= 1'b0;
      @(posedge clk);
      c_pull    = pull;
      deb       = d;
      dbl       = w;
      lng       = l;
    end
  endtask

  // pin level for a pressed or released button under the current polarity
  function automatic logic pin_for(input logic pressed);
    pin_for = pressed ? ~c_pull : c_pull;
  endfunction

  task automatic offer_level(input logic pressed);
    begin
      send_item(CMD_SAMPLE, pin_for(pressed), now_t);
    end
  endtask

  // hold (from press accepted to release seen) that still gives a short press
  function automatic int short_hold();
    int room;
    begin
      room = lng - deb - 2;
      short_hold = (room > 0) ? int'($urandom_range(room)) : 0;
    end
  endfunction

  // press length from acceptance of press to acceptance of release is
  // hold + debounce + 1, so the boundary pick lands on long-1, long, long+1
  function automatic int pick_hold();
    int b;
    begin
      case ($urandom_range(4))
        0, 1: pick_hold = short_hold();
        2: begin
          b = lng - deb - 2 + int'($urandom_range(2));
          pick_hold = (b < 0) ? 0 : b;
        end
        3: pick_hold = lng + int'($urandom_range(200));
        default: pick_hold = 0;
      endcase
    end
  endfunction

  // one press and release, each held just past the debounce time; optional
  // contact bounce in front and an optional sample inside the hold, often
  // right on the long-click threshold
  task automatic click(input int hold, input logic noisy);
    logic [31:0] base;
    int          mark;
    begin
      if (noisy && $urandom_range(3) == 0) begin
        repeat ($urandom_range(3, 1)) begin
          now_t += $urandom_range(deb + 1);
          send_item(CMD_SAMPLE, $urandom_range(1) != 0, now_t);
        end
      end
      offer_level(1'b1);
      now_t += deb + 1;
      offer_level(1'b1);
      base = now_t;
      if (hold > 0 && $urandom_range(1) != 0) begin
        if (lng >= 1 && lng <= hold && $urandom_range(1) != 0)
          mark = lng - int'($urandom_range(1));
        else
          mark = int'($urandom_range(hold));
        now_t = base + mark;
        offer_level(1'b1);
      end
      now_t = base + hold;
      offer_level(1'b0);
      now_t += deb + 1;
      offer_level(1'b0);
    end
  endtask

  // two short clicks, the second release placed mostly right at the edge of
  // the double-click window
  task automatic click_pair();
    int h2;
    int gap;
    int target;
    begin
      click(short_hold(), 1'b1);
      h2 = short_hold();
      if ($urandom_range(2) != 0) target = dbl - 1 + int'($urandom_range(2));
      else target = int'($urandom_range(2 * dbl + 2));
      gap = target - 2 * (deb + 1) - h2;
      now_t += (gap < 1) ? 1 : gap;
      click(h2, 1'b0);
    end
  endtask

  // unstructured item: random pin, occasional resync, occasional time jump
  task automatic noise();
    begin
      if ($urandom_range(15) == 0) now_t = $urandom;
      else now_t += $urandom_range(2 * deb + 3);
      send_item(($urandom_range(15) == 0) ? CMD_RESYNC : CMD_SAMPLE,
                $urandom_range(1) != 0, now_t);
    end
  endtask

  // mostly well-formed clicking with random timing, the rest noise, resyncs and quiet spells
  task automatic run_phase(input int n);
    int stop;
    begin
      stop = n_sent + n;
      while (n_sent < stop) begin
        case ($urandom_range(9))
          0, 1, 2, 3: click(pick_hold(), 1'b1);
          4, 5: click_pair();
          6, 7: repeat ($urandom_range(4, 1)) noise();
          8: begin
            now_t += $urandom_range(dbl + 50);
            send_item(CMD_RESYNC, $urandom_range(1) != 0, now_t);
          end
          default: begin
            // quiet spell so a pending first click can expire
            now_t += $urandom_range(2 * dbl + 2);
            offer_level(1'b0);
          end
        endcase
      end
    end
  endtask

  initial begin
    c_pull    = RST_PULL_UP_MODE;
    deb       = RST_DEBOUNCE_MS;
    dbl       = RST_DOUBLE_CLICK_MS;
    lng       = RST_LONG_CLICK_MS;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) send_item(script[i].cmd, script[i].pin_level, script[i].now_ms);
    now_t = 32'hFFFF_FFFF;

    set_config(1'b1, 1'b1, 20, 150, 400);
    run_phase(300);

    // active high with every time at zero
    set_config(1'b1, 1'b0, 0, 0, 0);
    run_phase(200);

    // every time at its largest, starting just short of the wrap
    now_t = 32'hFFFA_0000;
    set_config(1'b1, 1'b1, 65535, 65535, 65535);
    run_phase(150);

    set_config(1'b1, 1'b0, 7, 60, 90);
    run_phase(60);
    hold_req <= hold_req + 1;
    run_phase(140);

    // no pin: samples change nothing, resync only clears counters and the ignore flag
    set_config(1'b0, 1'b1, 3, 40, 80);
    run_phase(100);

    // a long stretch with no idling on either side
    set_config(1'b1, 1'b1, 0, 65535, 0);
    calm <= 1'b1;
    run_phase(150);
    calm <= 1'b0;

    set_config(1'b1, 1'b0, 2, 30, 50);
    run_phase(80);
    hold_req <= hold_req + 1;
    run_phase(170);

    drain();
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ button_click_classifier.f @@
design/bcc_pkg.sv
design/bcc_core.sv
design/button_click_classifier.sv
design/bcc_checker.sv
bench/bcc_checker.sv
bench/tb_button_click_classifier.sv
